### rtl/double_to_decimal_text_top_macros.svh
// Assertion macros for the decimal text converter.
`ifndef DOUBLE_TO_DECIMAL_TEXT_TOP_MACROS_SVH
`define DOUBLE_TO_DECIMAL_TEXT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define D2T_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define D2T_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define D2T_ASSERT(lbl, prop, msg)
`define D2T_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/d2t_pkg.sv
// Shared types, constants and BCD helper for the decimal text converter.
`default_nettype none
package d2t_pkg;
  localparam int MaxPrec = 15;
  localparam int PrecW   = 4;
  localparam int Digits  = 20;
  localparam int BcdW    = 4 * Digits;
  localparam int ProdW   = 103;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharNone  = 8'h00;

  // one classified number waiting for the back end
  typedef struct packed {
    logic               flag;
    logic               neg;
    logic [63:0]        ipart;
    logic [52:0]        mant;
    logic signed [11:0] e2;
    logic [PrecW-1:0]   prec;
  } job_t;

  // four double-dabble steps, nibble fed msb first
  function automatic logic [BcdW-1:0] dabble4(input logic [BcdW-1:0] bcd,
                                              input logic [3:0] nib);
    logic [BcdW-1:0] b;
    b = bcd;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < Digits; d++) begin
        if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
      end
      b = {b[BcdW-2:0], nib[s]};
    end
    return b;
  endfunction
endpackage
`default_nettype wire

### rtl/d2t_front.sv
// Front end: takes input beats and classifies the double.
`default_nettype none
module d2t_front import d2t_pkg::*; (
  input  wire logic             s_tvalid_i,
  output logic                  s_tready_o,
  input  wire logic [63:0]      s_tdata_i,
  input  wire logic [PrecW-1:0] precision_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output job_t                  job_o
);
  logic [10:0] expo;
  logic [51:0] frac;
  logic [63:0] sig;
  logic [10:0] expo_eff;

  assign expo = s_tdata_i[62:52];
  assign frac = s_tdata_i[51:0];
  assign sig  = {11'b0, (expo != 11'd0), frac};
  assign expo_eff = (expo == 11'd0) ? 11'd1 : expo;

  assign s_tready_o = !q_full_i;
  assign push_o     = s_tvalid_i && !q_full_i;

  // classify: specials and range, sign, integer part, scaling exponent, precision clamp
  always_comb begin
    job_o.flag = (expo == 11'h7FF) || (expo >= 11'd1086);
    job_o.neg  = s_tdata_i[63] && ((expo != 11'd0) || (frac != 52'd0));
    if (expo < 11'd1023) job_o.ipart = 64'd0;
    else if (expo >= 11'd1075) job_o.ipart = sig << (expo - 11'd1075);
    else job_o.ipart = sig >> (11'd1075 - expo);
    job_o.mant = sig[52:0];
    job_o.e2   = $signed({1'b0, expo_eff}) - 12'sd1075;
    job_o.prec = (precision_i > PrecW'(MaxPrec)) ? PrecW'(MaxPrec) : precision_i;
  end
endmodule
`default_nettype wire

### rtl/d2t_queue.sv
// Two-entry queue of classified numbers between front and back.
`default_nettype none
module d2t_queue import d2t_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);
  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= job_i;
  end
endmodule
`default_nettype wire

### rtl/d2t_back.sv
// Back end: scaled multiply, rounding, BCD conversion and character output.
`default_nettype none
module d2t_back import d2t_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  job_t            job_i,
  output logic            pop_o,
  output logic            m_tvalid_o,
  input  wire logic       m_tready_i,
  output logic [7:0]      m_tdata_o,
  output logic            m_tlast_o,
  output logic            m_tuser_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_NORM, S_ROUND, S_BCDI, S_BCDF, S_PREP,
    S_SIGN, S_INT, S_DOT, S_FRAC, S_FLAG
  } state_e;

  state_e             state_q;
  logic               neg_q;
  logic [PrecW-1:0]   prec_q, cnt_q, fi_q;
  logic signed [11:0] e2_q;
  logic [ProdW-1:0]   prod_q;
  logic [6:0]         shift_q;
  logic [63:0]        src_q, fpart_q;
  logic [BcdW-1:0]    bcd_q, bcdi_q;
  logic [3:0]         nib_q;
  logic [4:0]         di_q;
  logic               out_valid_q, out_last_q, out_flag_q;
  logic [7:0]         out_char_q;

  logic               out_free;
  logic               emit;
  logic [4:0]         ndig;
  logic               sticky, rnd, carry, ovf;
  logic [53:0]        r54;
  logic [52:0]        rsig;
  logic signed [12:0] e2v, nsh;
  logic [63:0]        fpart;
  logic [BcdW-1:0]    bcd_nx;

  assign out_free = !out_valid_q || m_tready_i;
  assign pop_o    = (state_q == S_IDLE) && q_valid_i;
  assign bcd_nx   = dabble4(bcd_q, src_q[63:60]);

  // a new beat is loaded into the output register this cycle
  assign emit = out_free && ((state_q == S_SIGN) || (state_q == S_INT) ||
                             (state_q == S_DOT) || (state_q == S_FRAC) ||
                             (state_q == S_FLAG));

  // leading digit of the integer part
  always_comb begin
    ndig = 5'd0;
    for (int d = 0; d < Digits; d++) begin
      if (bcdi_q[d*4 +: 4] != 4'd0) ndig = 5'(d);
    end
  end

  // round the normalized product to 53 bits, then truncate to integer
  always_comb begin
    sticky = |prod_q[48:0];
    rnd    = prod_q[49] && (prod_q[50] || sticky);
    r54    = {1'b0, prod_q[102:50]} + 54'(rnd);
    carry  = r54[53];
    rsig   = carry ? r54[53:1] : r54[52:0];
    e2v    = $signed({e2_q[11], e2_q}) + 13'sd50 - $signed({6'b0, shift_q})
             + $signed({12'b0, carry});
    ovf    = (e2v > 13'sd10);
    nsh    = -e2v;
    if (!e2v[12]) fpart = {11'b0, rsig} << e2v[3:0];
    else if (nsh > 13'sd63) fpart = 64'd0;
    else fpart = {11'b0, rsig} >> nsh[5:0];
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      prec_q      <= '0;
      cnt_q       <= '0;
      fi_q        <= '0;
      e2_q        <= '0;
      prod_q      <= '0;
      shift_q     <= '0;
      src_q       <= '0;
      fpart_q     <= '0;
      bcd_q       <= '0;
      bcdi_q      <= '0;
      nib_q       <= '0;
      di_q        <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_flag_q  <= 1'b0;
      out_char_q  <= '0;
    end else begin
      if (m_tready_i && !emit) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            neg_q   <= job_i.neg;
            prec_q  <= job_i.prec;
            cnt_q   <= job_i.prec;
            e2_q    <= job_i.e2;
            prod_q  <= ProdW'(job_i.mant);
            shift_q <= '0;
            src_q   <= job_i.ipart;
            bcd_q   <= '0;
            nib_q   <= '0;
            if (job_i.flag) state_q <= S_FLAG;
            else if (job_i.prec == '0) state_q <= S_BCDI;
            else state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt_q != '0) begin
            prod_q <= (prod_q << 3) + (prod_q << 1);
            cnt_q  <= cnt_q - 1'b1;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (prod_q == '0) begin
            fpart_q <= '0;
            state_q <= S_BCDI;
          end else if (prod_q[102:95] == 8'd0) begin
            prod_q  <= prod_q << 8;
            shift_q <= shift_q + 7'd8;
          end else if (!prod_q[102]) begin
            prod_q  <= prod_q << 1;
            shift_q <= shift_q + 7'd1;
          end else begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          fpart_q <= fpart;
          state_q <= ovf ? S_FLAG : S_BCDI;
        end
        S_BCDI: begin
          bcd_q <= bcd_nx;
          src_q <= src_q << 4;
          nib_q <= nib_q + 4'd1;
          if (nib_q == 4'd15) begin
            bcdi_q <= bcd_nx;
            if (prec_q != '0) begin
              src_q   <= fpart_q;
              bcd_q   <= '0;
              state_q <= S_BCDF;
            end else begin
              state_q <= S_PREP;
            end
          end
        end
        S_BCDF: begin
          bcd_q <= bcd_nx;
          src_q <= src_q << 4;
          nib_q <= nib_q + 4'd1;
          if (nib_q == 4'd15) state_q <= S_PREP;
        end
        S_PREP: begin
          di_q    <= ndig;
          state_q <= neg_q ? S_SIGN : S_INT;
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CharMinus;
            out_last_q  <= 1'b0;
            out_flag_q  <= 1'b0;
            state_q     <= S_INT;
          end
        end
        S_INT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CharZero + {4'b0, bcdi_q[di_q*4 +: 4]};
            out_last_q  <= (di_q == 5'd0) && (prec_q == '0);
            out_flag_q  <= 1'b0;
            if (di_q != 5'd0) di_q <= di_q - 5'd1;
            else state_q <= (prec_q != '0) ? S_DOT : S_IDLE;
          end
        end
        S_DOT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CharDot;
            out_last_q  <= 1'b0;
            out_flag_q  <= 1'b0;
            fi_q        <= prec_q - 1'b1;
            state_q     <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CharZero + {4'b0, bcd_q[fi_q*4 +: 4]};
            out_last_q  <= (fi_q == '0);
            out_flag_q  <= 1'b0;
            if (fi_q != '0) fi_q <= fi_q - 1'b1;
            else state_q <= S_IDLE;
          end
        end
        S_FLAG: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CharNone;
            out_last_q  <= 1'b1;
            out_flag_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_char_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_flag_q;
endmodule
`default_nettype wire

### rtl/double_to_decimal_text_top.sv
// Top level of the double to decimal text converter.
//
//  channel   dir  carries
//  s_axis    in   tdata[63:0] value_bits
//  m_axis    out  tdata[7:0] out_char, tlast last_char, tuser out_of_range
//  cfg       in   cfg_wdata_i[3:0] precision, written when cfg_we_i is high
//
// Each number runs a serial x10 loop, normalization and rounding, an integer
// and a fractional BCD pass, then one character per output beat; with
// precision 0 the loop, normalizing, rounding and fraction pass are skipped.
// A two-entry queue lets the front take new beats while the back works.
// Flagged numbers leave after the load or rounding step as a single beat.
// Reset is asynchronous active low; precision resets to 6.
`default_nettype none
`include "double_to_decimal_text_top_macros.svh"
module double_to_decimal_text_top import d2t_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [63:0]      s_axis_tdata_i,   // [63:0] value_bits
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,   // [7:0] out_char
  output logic                  m_axis_tlast_o,
  output logic                  m_axis_tuser_o,   // [0] out_of_range
  input  wire logic             cfg_we_i,
  input  wire logic [PrecW-1:0] cfg_wdata_i
);
  logic [PrecW-1:0] prec_q;
  logic             q_full, q_push, q_pop, q_valid;
  job_t             job_in, job_out;

  // precision register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prec_q <= PrecW'(6);
    else if (cfg_we_i) prec_q <= cfg_wdata_i;
  end

  d2t_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .precision_i(prec_q),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (job_in)
  );

  d2t_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (job_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .job_o  (job_out)
  );

  d2t_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .job_i     (job_out),
    .pop_o     (q_pop),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_tdata_o (m_axis_tdata_o),
    .m_tlast_o (m_axis_tlast_o),
    .m_tuser_o (m_axis_tuser_o)
  );

  // a range flag beat is a lone final beat with a null character
  `D2T_ASSERT(a_flag_lone, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o == CharNone, "flag beat malformed")
  // ordinary beats carry only digits, minus or dot
  `D2T_ASSERT(a_char_legal, m_axis_tvalid_o && !m_axis_tuser_o |-> (m_axis_tdata_o >= CharZero && m_axis_tdata_o <= 8'h39) || m_axis_tdata_o == CharMinus || m_axis_tdata_o == CharDot, "illegal character")
  // a minus is never the last character
  `D2T_ASSERT(a_minus_not_last, m_axis_tvalid_o && m_axis_tdata_o == CharMinus |-> !m_axis_tlast_o, "text ends in minus")
  // reset leaves the output not valid
  `D2T_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid_o, "output valid in reset")
endmodule
`default_nettype wire

### test/double_to_decimal_text_top_tb.sv
// Self-checking testbench for the double to decimal text converter.
`default_nettype none
module double_to_decimal_text_top_tb import d2t_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       oor;
  } text_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [63:0]      s_axis_tdata_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [7:0]       m_axis_tdata_o;
  logic             m_axis_tlast_o;
  logic             m_axis_tuser_o;
  logic             cfg_we_i = 1'b0;
  logic [PrecW-1:0] cfg_wdata_i = '0;

  logic [63:0]      value_q[$];
  text_beat_t       text_q[$];
  logic [PrecW-1:0] prec_shadow = 4'd6;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_len = 0;
  int               errors = 0;
  int               idle_cycles = 0;
  logic             s_took = 1'b0;

  double_to_decimal_text_top dut (.*);

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // integer part of a non-negative double below 2^63
  function automatic logic [63:0] trunc_mag(input real r);
    logic [63:0] b;
    logic [63:0] m;
    int          e;
    b = $realtobits(r);
    e = int'(b[62:52]);
    if (e < 1023) return 64'd0;
    m = {11'd0, 1'b1, b[51:0]};
    if (e >= 1075) return m << (e - 1075);
    return m >> (1075 - e);
  endfunction

  // expected characters of one number
  task automatic predict_text(input logic [63:0] bits);
    text_beat_t  t[$];
    text_beat_t  c;
    logic [7:0]  digs[$];
    logic [63:0] ip, fp;
    real         v, mag, scale, scaled;
    int          p;
    p = (prec_shadow > MaxPrec) ? MaxPrec : int'(prec_shadow);
    c.last = 1'b0;
    c.oor = 1'b0;
    if (bits[62:52] == 11'h7FF) begin
      text_q.push_back('{CharNone, 1'b1, 1'b1});
      return;
    end
    v = $bitstoreal(bits);
    mag = (v < 0.0) ? -v : v;
    if (mag >= 9223372036854775808.0) begin
      text_q.push_back('{CharNone, 1'b1, 1'b1});
      return;
    end
    if (v < 0.0) begin
      c.ch = CharMinus;
      t.push_back(c);
    end
    ip = trunc_mag(mag);
    do begin
      digs.push_front(CharZero + 8'(ip % 10));
      ip = ip / 10;
    end while (ip != 0);
    foreach (digs[i]) begin
      c.ch = digs[i];
      t.push_back(c);
    end
    if (p != 0) begin
      scale = 1.0;
      for (int k = 0; k < p; k++) scale = scale * 10.0;
      scaled = mag * scale;
      if (scaled >= 9223372036854775808.0) begin
        text_q.push_back('{CharNone, 1'b1, 1'b1});
        return;
      end
      fp = trunc_mag(scaled);
      c.ch = CharDot;
      t.push_back(c);
      digs.delete();
      for (int k = 0; k < p; k++) begin
        digs.push_front(CharZero + 8'(fp % 10));
        fp = fp / 10;
      end
      foreach (digs[i]) begin
        c.ch = digs[i];
        t.push_back(c);
      end
    end
    t[t.size() - 1].last = 1'b1;
    foreach (t[i]) text_q.push_back(t[i]);
  endtask

  // sender: next value at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || s_took)) begin
      if (value_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata_i <= value_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus long hold-off
  always @(negedge clk_i) begin
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input beats, check output beats, watchdog
  always @(posedge clk_i) begin
    text_beat_t e;
    s_took <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) predict_text(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (text_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat char=%h", m_axis_tdata_o);
        end else begin
          e = text_q.pop_front();
          if (e.ch !== m_axis_tdata_o || e.last !== m_axis_tlast_o ||
              e.oor !== m_axis_tuser_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp char=%h last=%b oor=%b got char=%h last=%b oor=%b",
                       e.ch, e.last, e.oor, m_axis_tdata_o, m_axis_tlast_o,
                       m_axis_tuser_o);
          end
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 30000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // random double, mostly with moderate exponents
  function automatic logic [63:0] rand_value();
    logic [63:0] b;
    b = {$urandom, $urandom};
    if ($urandom_range(9) < 7) b[62:52] = 11'($urandom_range(1023 + 45, 1023 - 25));
    return b;
  endfunction

  task automatic drain();
    while (value_q.size() != 0 || s_axis_tvalid_i || text_q.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_precision(input logic [PrecW-1:0] p);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    prec_shadow = p;
  endtask

  initial begin
    logic [PrecW-1:0] precs[5] = '{4'd0, 4'd15, 4'd1, 4'd9, 4'd3};
    int               stalls[5][2] = '{'{0, 0}, '{82, 0}, '{0, 82}, '{20, 20}, '{0, 0}};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed values under reset precision
    value_q = '{64'h0, 64'h8000_0000_0000_0000, 64'h3FE0_0000_0000_0000,
                64'hBFE0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                64'h405E_DD2F_1A9F_BE77, 64'h43DF_FFFF_FFFF_FFFF,
                64'hC3DF_FFFF_FFFF_FFFF, 64'h43E0_0000_0000_0000,
                64'hC3E0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                64'h7FEF_FFFF_FFFF_FFFF, 64'h3FB9_9999_9999_999A,
                64'h4202_A05F_2000_0000, 64'h4023_FFFF_FFFF_FFFF};
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      set_precision(precs[ph]);
      send_idle_pct = stalls[ph][0];
      recv_stall_pct = stalls[ph][1];
      value_q.push_back(64'h4202_A05F_2000_0000);
      value_q.push_back(64'hBFE0_0000_0000_0000);
      for (int i = 0; i < 25; i++) value_q.push_back(rand_value());
      // long receiver hold while the sender keeps offering
      if (ph == 4) hold_len = 500;
      // sender pauses until everything has come out
      drain();
      for (int i = 0; i < 25; i++) value_q.push_back(rand_value());
      drain();
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/d2t_pkg.sv
rtl/d2t_front.sv
rtl/d2t_queue.sv
rtl/d2t_back.sv
rtl/double_to_decimal_text_top.sv
test/double_to_decimal_text_top_tb.sv
